[rtl/prc_pkg.sv]
// Shared types, constants and the arctangent table of the Park rotation CORDIC.
package prc_pkg;

   // default number of CORDIC cells (8 to 31)
   localparam int CORDIC_ITERATIONS = 24;

   // CORDIC x/y/z datapath width, with headroom over Q1.31
   localparam int XY_W = 34;

   // angle constants, radians in Q4.27
   localparam logic signed [33:0] PI_Q27     = 34'sd421657428;
   localparam logic signed [33:0] TWO_PI_Q27 = 34'sd843314856;

   // 2^31 / pi as an unsigned integer (Q30.0): radians to half-turn scale
   localparam logic [29:0] RAD_TO_HALFTURN = 30'd683565275;

   // inverse of the converged CORDIC gain in Q1.31
   localparam logic signed [XY_W-1:0] CORDIC_GAIN_Q31 = 34'sd1304065748;

   // Q1.31 and Q15.16 limits
   localparam logic signed [34:0] Q31_MAX_35 = 35'sd2147483647;
   localparam logic signed [33:0] Q31_MAX_34 = 34'sd2147483647;
   localparam logic signed [33:0] Q31_MIN_34 = -34'sd2147483648;

   // operation codes
   localparam logic OP_FORWARD = 1'b0;
   localparam logic OP_INVERSE = 1'b1;

   // vector and operation, carried alongside the angle
   typedef struct packed {
      logic               op;
      logic signed [31:0] a;
      logic signed [31:0] b;
   } vec_type;

   // payload passed between CORDIC cells
   typedef struct packed {
      vec_type                vec;
      logic                   flip;
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [XY_W-1:0] z;
   } cordic_type;

   // arctangent of 2^-i as a Q1.31 half-turn angle
   function automatic logic [31:0] atan_halfturn(input logic [4:0] idx);
      logic [31:0] val;
      case (idx)
         5'd0:    val = 32'h20000000;
         5'd1:    val = 32'h12E4051E;
         5'd2:    val = 32'h09FB385B;
         5'd3:    val = 32'h051111D4;
         5'd4:    val = 32'h028B0D43;
         5'd5:    val = 32'h0145D7E1;
         5'd6:    val = 32'h00A2F61E;
         5'd7:    val = 32'h00517C55;
         5'd8:    val = 32'h0028BE53;
         5'd9:    val = 32'h00145F2F;
         5'd10:   val = 32'h000A2F98;
         5'd11:   val = 32'h000517CC;
         5'd12:   val = 32'h00028BE6;
         5'd13:   val = 32'h000145F3;
         5'd14:   val = 32'h0000A2FA;
         5'd15:   val = 32'h0000517D;
         5'd16:   val = 32'h000028BE;
         5'd17:   val = 32'h0000145F;
         5'd18:   val = 32'h00000A30;
         5'd19:   val = 32'h00000518;
         5'd20:   val = 32'h0000028C;
         5'd21:   val = 32'h00000146;
         5'd22:   val = 32'h000000A3;
         5'd23:   val = 32'h00000051;
         5'd24:   val = 32'h00000029;
         5'd25:   val = 32'h00000014;
         5'd26:   val = 32'h0000000A;
         5'd27:   val = 32'h00000005;
         5'd28:   val = 32'h00000003;
         5'd29:   val = 32'h00000001;
         5'd30:   val = 32'h00000001;
         default: val = 32'h00000000;
      endcase
      return val;
   endfunction

endpackage

[rtl/prc_angle.sv]
// Angle front end: wrap once by 2*pi toward [-pi,pi), scale to a half-turn angle, fold to the right half plane.
module prc_angle (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  prc_pkg::vec_type    in_vec,
   input  logic signed [31:0]  in_angle,
   output logic                out_valid,
   input  logic                out_ready,
   output prc_pkg::cordic_type out_data
);

   // stage 1 registers: scaled magnitude product
   logic             s1_valid_ff;
   logic             s1_ready;
   prc_pkg::vec_type s1_vec_ff;
   logic [60:0]      s1_prod_ff;
   logic [60:0]      s1_prod_in;
   logic             s1_neg_ff;
   logic             s1_neg_in;

   // stage 2 registers: CORDIC start values
   logic                s2_valid_ff;
   logic                s2_ready;
   prc_pkg::cordic_type s2_data_ff;
   prc_pkg::cordic_type s2_data_in;

   logic signed [33:0] ang_ext;
   logic signed [33:0] wrapped;
   logic signed [33:0] wrapped_neg;
   logic [30:0]        mag;
   logic [31:0]        q32;
   logic [31:0]        hturn;
   logic               flip;

   assign s2_ready  = !s2_valid_ff || out_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign in_ready  = s1_ready;
   assign out_valid = s2_valid_ff;
   assign out_data  = s2_data_ff;

   // wrap once by 2*pi and scale the magnitude
   always_comb begin
      ang_ext = {{2{in_angle[31]}}, in_angle};
      if (ang_ext >= prc_pkg::PI_Q27) begin
         wrapped = ang_ext - prc_pkg::TWO_PI_Q27;
      end else if (ang_ext < -prc_pkg::PI_Q27) begin
         wrapped = ang_ext + prc_pkg::TWO_PI_Q27;
      end else begin
         wrapped = ang_ext;
      end
      wrapped_neg = -wrapped;
      mag         = wrapped[33] ? wrapped_neg[30:0] : wrapped[30:0];
      s1_neg_in   = wrapped[33];
      s1_prod_in  = 61'(mag) * 61'(prc_pkg::RAD_TO_HALFTURN);
   end

   // truncate, restore sign, fold quadrants 2 and 3 by a half turn
   always_comb begin
      q32   = s1_prod_ff[58:27];
      hturn = s1_neg_ff ? (32'd0 - q32) : q32;
      flip  = hturn[31] ^ hturn[30];
      s2_data_in.vec  = s1_vec_ff;
      s2_data_in.flip = flip;
      s2_data_in.x    = prc_pkg::CORDIC_GAIN_Q31;
      s2_data_in.y    = '0;
      s2_data_in.z    = {{2{hturn[31] ^ flip}}, hturn[31] ^ flip, hturn[30:0]};
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= in_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) begin
         s1_vec_ff  <= in_vec;
         s1_prod_ff <= s1_prod_in;
         s1_neg_ff  <= s1_neg_in;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_data_ff <= s2_data_in;
      end
   end

endmodule

[rtl/prc_cordic_cell.sv]
// One rotation-mode CORDIC iteration with its own pipeline register.
module prc_cordic_cell #(
   parameter int SHIFT = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  prc_pkg::cordic_type in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output prc_pkg::cordic_type out_data
);

   logic                            valid_ff;
   prc_pkg::cordic_type             data_ff;
   prc_pkg::cordic_type             data_in;
   logic signed [prc_pkg::XY_W-1:0] x_sh;
   logic signed [prc_pkg::XY_W-1:0] y_sh;
   logic signed [prc_pkg::XY_W-1:0] step;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // micro-rotation toward z = 0
   always_comb begin
      x_sh    = in_data.x >>> SHIFT;
      y_sh    = in_data.y >>> SHIFT;
      step    = {{(prc_pkg::XY_W-32){1'b0}}, prc_pkg::atan_halfturn(5'(SHIFT))};
      data_in = in_data;
      if (!in_data.z[prc_pkg::XY_W-1]) begin
         data_in.x = in_data.x - y_sh;
         data_in.y = in_data.y + x_sh;
         data_in.z = in_data.z - step;
      end else begin
         data_in.x = in_data.x + y_sh;
         data_in.y = in_data.y - x_sh;
         data_in.z = in_data.z + step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

[rtl/prc_rotate.sv]
// Back end: unfold and clamp sine/cosine, multiply, round and saturate the rotated vector.
module prc_rotate (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  prc_pkg::cordic_type in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output logic signed [31:0]  out_first,
   output logic signed [31:0]  out_second
);

   // stage 1: clamped sine and cosine
   logic               s1_valid_ff;
   logic               s1_ready;
   prc_pkg::vec_type   s1_vec_ff;
   logic signed [31:0] s1_cos_ff;
   logic signed [31:0] s1_cos_in;
   logic signed [31:0] s1_sin_ff;
   logic signed [31:0] s1_sin_in;

   // stage 2: products
   logic               s2_valid_ff;
   logic               s2_ready;
   logic               s2_op_ff;
   logic signed [63:0] s2_ac_ff;
   logic signed [63:0] s2_bs_ff;
   logic signed [63:0] s2_bc_ff;
   logic signed [63:0] s2_as_ff;
   logic signed [63:0] s2_ac_in;
   logic signed [63:0] s2_bs_in;
   logic signed [63:0] s2_bc_in;
   logic signed [63:0] s2_as_in;

   // stage 3: output register
   logic               s3_valid_ff;
   logic               s3_ready;
   logic signed [31:0] s3_first_ff;
   logic signed [31:0] s3_first_in;
   logic signed [31:0] s3_second_ff;
   logic signed [31:0] s3_second_in;

   logic signed [34:0] cx;
   logic signed [34:0] cy;
   logic signed [64:0] sum_first;
   logic signed [64:0] sum_second;
   logic signed [64:0] rnd_first;
   logic signed [64:0] rnd_second;
   logic signed [33:0] r_first;
   logic signed [33:0] r_second;

   assign s3_ready   = !s3_valid_ff || out_ready;
   assign s2_ready   = !s2_valid_ff || s3_ready;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign in_ready   = s1_ready;
   assign out_valid  = s3_valid_ff;
   assign out_first  = s3_first_ff;
   assign out_second = s3_second_ff;

   // undo the half-turn fold, clamp to +-(2^31-1)
   always_comb begin
      cx = in_data.flip ? -{in_data.x[33], in_data.x} : {in_data.x[33], in_data.x};
      cy = in_data.flip ? -{in_data.y[33], in_data.y} : {in_data.y[33], in_data.y};
      if (cx > prc_pkg::Q31_MAX_35) begin
         s1_cos_in = 32'sh7FFFFFFF;
      end else if (cx < -prc_pkg::Q31_MAX_35) begin
         s1_cos_in = -32'sh7FFFFFFF;
      end else begin
         s1_cos_in = cx[31:0];
      end
      if (cy > prc_pkg::Q31_MAX_35) begin
         s1_sin_in = 32'sh7FFFFFFF;
      end else if (cy < -prc_pkg::Q31_MAX_35) begin
         s1_sin_in = -32'sh7FFFFFFF;
      end else begin
         s1_sin_in = cy[31:0];
      end
   end

   // four 32x32 products
   always_comb begin
      s2_ac_in = s1_vec_ff.a * s1_cos_ff;
      s2_bs_in = s1_vec_ff.b * s1_sin_ff;
      s2_bc_in = s1_vec_ff.b * s1_cos_ff;
      s2_as_in = s1_vec_ff.a * s1_sin_ff;
   end

   // combine, round half up at bit 31, saturate
   always_comb begin
      if (s2_op_ff == prc_pkg::OP_INVERSE) begin
         sum_first  = {s2_ac_ff[63], s2_ac_ff} - {s2_bs_ff[63], s2_bs_ff};
         sum_second = {s2_as_ff[63], s2_as_ff} + {s2_bc_ff[63], s2_bc_ff};
      end else begin
         sum_first  = {s2_ac_ff[63], s2_ac_ff} + {s2_bs_ff[63], s2_bs_ff};
         sum_second = {s2_bc_ff[63], s2_bc_ff} - {s2_as_ff[63], s2_as_ff};
      end
      rnd_first  = sum_first + 65'sh40000000;
      rnd_second = sum_second + 65'sh40000000;
      r_first    = rnd_first[64:31];
      r_second   = rnd_second[64:31];
      if (r_first > prc_pkg::Q31_MAX_34) begin
         s3_first_in = 32'sh7FFFFFFF;
      end else if (r_first < prc_pkg::Q31_MIN_34) begin
         s3_first_in = 32'sh80000000;
      end else begin
         s3_first_in = r_first[31:0];
      end
      if (r_second > prc_pkg::Q31_MAX_34) begin
         s3_second_in = 32'sh7FFFFFFF;
      end else if (r_second < prc_pkg::Q31_MIN_34) begin
         s3_second_in = 32'sh80000000;
      end else begin
         s3_second_in = r_second[31:0];
      end
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= in_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) begin
         s1_vec_ff <= in_data.vec;
         s1_cos_ff <= s1_cos_in;
         s1_sin_ff <= s1_sin_in;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_op_ff <= s1_vec_ff.op;
         s2_ac_ff <= s2_ac_in;
         s2_bs_ff <= s2_bs_in;
         s2_bc_ff <= s2_bc_in;
         s2_as_ff <= s2_as_in;
      end
      if (s3_ready && s2_valid_ff) begin
         s3_first_ff  <= s3_first_in;
         s3_second_ff <= s3_second_in;
      end
   end

endmodule

[rtl/park_rotation_cordic.sv]
// Top level of the pipelined Park / inverse Park rotation with a CORDIC sine/cosine chain.
//
// Rotates a Q15.16 vector by an angle given in radians (Q4.27): tuser = 0 gives forward
// Park (alpha,beta to d,q), tuser = 1 gives inverse Park (d,q to alpha,beta). Results are
// rounded and saturated to Q15.16. The block is fully pipelined and takes one item per
// clock while no stall holds it off; its stages are two angle stages (wrap and scale
// multiply, then fold), one cell per CORDIC iteration, then clamp, multiply and round
// stages. Each stage has its own valid bit and holds its item only while the stage after
// it is full and stalled, so backpressure on rsp_tready is absorbed by bubbles in the
// chain before the input side is held off.
module park_rotation_cordic #(
   parameter int CORDIC_ITERATIONS = prc_pkg::CORDIC_ITERATIONS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [95:0]  req_tdata,   // first_in[31:0], second_in[63:32], angle[95:64]
   input  logic         req_tuser,   // op[0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [63:0]  rsp_tdata    // first_out[31:0], second_out[63:32]
);

   prc_pkg::vec_type    in_vec;
   logic signed [31:0]  in_angle;
   logic signed [31:0]  out_first;
   logic signed [31:0]  out_second;

   // links between cells: entry k feeds cell k
   logic                link_valid [0:CORDIC_ITERATIONS];
   logic                link_ready [0:CORDIC_ITERATIONS];
   prc_pkg::cordic_type link_data  [0:CORDIC_ITERATIONS];

   // unpack request
   always_comb begin
      in_vec.op = req_tuser;
      in_vec.a  = req_tdata[31:0];
      in_vec.b  = req_tdata[63:32];
      in_angle  = req_tdata[95:64];
   end

   prc_angle u_angle (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_vec    (in_vec),
      .in_angle  (in_angle),
      .out_valid (link_valid[0]),
      .out_ready (link_ready[0]),
      .out_data  (link_data[0])
   );

   // CORDIC chain, one iteration per cell
   for (genvar i = 0; i < CORDIC_ITERATIONS; i++) begin : g_cell
      prc_cordic_cell #(
         .SHIFT (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (link_valid[i]),
         .in_ready  (link_ready[i]),
         .in_data   (link_data[i]),
         .out_valid (link_valid[i+1]),
         .out_ready (link_ready[i+1]),
         .out_data  (link_data[i+1])
      );
   end

   prc_rotate u_rotate (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (link_valid[CORDIC_ITERATIONS]),
      .in_ready   (link_ready[CORDIC_ITERATIONS]),
      .in_data    (link_data[CORDIC_ITERATIONS]),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_first  (out_first),
      .out_second (out_second)
   );

   assign rsp_tdata = {out_second, out_first};

endmodule

[rtl/prc_checker.sv]
// Port-level checks for the Park rotation CORDIC, bound to the top level.
module prc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata
);

   // a stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // a stalled result holds its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result changed while stalled");

   // the pipeline comes out of reset empty
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

   // an output that is free or draining leaves the input open
   assert property (@(posedge clock) disable iff (reset)
      rsp_tready || !rsp_tvalid |-> req_tready)
      else $error("input held off with a free output");

endmodule

bind park_rotation_cordic prc_checker u_prc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
